// ===== src/ecr_pkg.sv =====
// ecr_pkg: shared widths, breakpoint height and color tables, queue depths
// for the elevation color ramp; no dependencies
package ecr_pkg;

  localparam int BREAKPOINTS   = 18;
  localparam int FRAC_BITS_DEF = 4;
  localparam int ELEV_W        = 24;
  localparam int COLOR_W       = 8;
  localparam int BAND_W        = 5;
  // breakpoint heights in whole meters, signed
  localparam int LVLM_W        = 15;
  // widest gap between neighbor breakpoints in whole meters
  localparam int SPANM_W       = 12;
  localparam int MID_DEPTH     = 4;
  localparam int OUT_DEPTH     = 16;

  typedef logic signed [LVLM_W-1:0] lvlm_t;
  typedef logic [COLOR_W-1:0]       color_t;
  typedef logic [BAND_W-1:0]        band_t;

  // breakpoint heights, rising
  localparam lvlm_t LVL_M [BREAKPOINTS] = '{
    -15'sd4000, -15'sd2000, -15'sd1000, -15'sd200, -15'sd20, 15'sd0,
    15'sd50, 15'sd100, 15'sd200, 15'sd500, 15'sd1000, 15'sd1500,
    15'sd2500, 15'sd3000, 15'sd4000, 15'sd5000, 15'sd6000, 15'sd9000
  };

  // color at each breakpoint: red, green, blue
  localparam color_t RGB [BREAKPOINTS][3] = '{
    '{8'd76,  8'd142, 8'd191}, '{8'd100, 8'd159, 8'd204},
    '{8'd126, 8'd177, 8'd217}, '{8'd154, 8'd197, 8'd230},
    '{8'd184, 8'd217, 8'd243}, '{8'd160, 8'd204, 8'd126},
    '{8'd160, 8'd200, 8'd133}, '{8'd165, 8'd195, 8'd140},
    '{8'd157, 8'd180, 8'd130}, '{8'd149, 8'd169, 8'd101},
    '{8'd159, 8'd165, 8'd105}, '{8'd200, 8'd205, 8'd150},
    '{8'd241, 8'd232, 8'd204}, '{8'd221, 8'd198, 8'd142},
    '{8'd213, 8'd180, 8'd120}, '{8'd229, 8'd213, 8'd186},
    '{8'd245, 8'd238, 8'd255}, '{8'd231, 8'd227, 8'd255}
  };

  // height of segment seg in whole meters (next breakpoint minus this one)
  function automatic logic [SPANM_W-1:0] span_m(input band_t seg);
    band_t                   nxt;
    logic signed [LVLM_W:0]  diff;
    nxt  = seg + 1'b1;
    diff = (LVLM_W+1)'(LVL_M[nxt]) - (LVLM_W+1)'(LVL_M[seg]);
    return diff[SPANM_W-1:0];
  endfunction

endpackage

// ===== src/ecr_fifo.sv =====
// ecr_fifo: small first-word-fall-through register queue
// depends on nothing; DEPTH must be a power of two
module ecr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

// ===== src/ecr_front.sv =====
// ecr_front: classifies an elevation sample into a ramp segment and offset
// depends on ecr_pkg
module ecr_front
  import ecr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic signed [ELEV_W-1:0]          elevation,
  output band_t                             band,
  output band_t                             seg,
  output logic [SPANM_W+FRAC_BITS-1:0]      off
);

  localparam int SPAN_W = SPANM_W + FRAC_BITS;
  localparam int LVL_W  = LVLM_W + FRAC_BITS;
  localparam int CMP_W  = ((LVL_W > ELEV_W) ? LVL_W : ELEV_W) + 1;

  logic signed [CMP_W-1:0] lvl_s [BREAKPOINTS];
  logic [BREAKPOINTS-1:0]  ge;
  logic signed [CMP_W-1:0] e_s;
  logic signed [CMP_W-1:0] diff;
  band_t                   idx;

  assign e_s = CMP_W'(elevation);

  // scaled breakpoints and one compare per breakpoint
  for (genvar i = 0; i < BREAKPOINTS; i++) begin : g_cmp
    assign lvl_s[i] = CMP_W'(LVL_M[i]) <<< FRAC_BITS;
    assign ge[i]    = (e_s >= lvl_s[i]);
  end

  // highest breakpoint at or below the sample
  always_comb begin
    idx = '0;
    for (int i = 0; i < BREAKPOINTS; i++) begin
      if (ge[i]) begin
        idx = BAND_W'(i);
      end
    end
  end

  assign diff = e_s - lvl_s[idx];

  // below the ramp: first color; at or above the top: end of last segment
  always_comb begin
    if (!ge[0]) begin
      band = '0;
      seg  = '0;
      off  = '0;
    end else if (idx == BAND_W'(BREAKPOINTS - 1)) begin
      band = BAND_W'(BREAKPOINTS - 1);
      seg  = BAND_W'(BREAKPOINTS - 2);
      off  = SPAN_W'(span_m(BAND_W'(BREAKPOINTS - 2))) << FRAC_BITS;
    end else begin
      band = idx;
      seg  = idx;
      off  = diff[SPAN_W-1:0];
    end
  end

endmodule

// ===== src/ecr_back.sv =====
// ecr_back: interpolation pipeline, one multiply stage then a pipelined
// long division per channel, issue gated by output queue credits; uses ecr_pkg
module ecr_back
  import ecr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          mid_empty,
  input  logic [2*BAND_W+SPANM_W+FRAC_BITS-1:0]         mid_word,
  output logic                                          mid_pop,
  input  logic                                          drain,
  output logic                                          out_push,
  output logic [BAND_W+3*COLOR_W-1:0]                   out_word
);

  localparam int SPAN_W = SPANM_W + FRAC_BITS;
  localparam int U_W    = SPAN_W + COLOR_W + 2;
  localparam int QUOT_W = COLOR_W;
  localparam int CRD_W  = $clog2(OUT_DEPTH + 1);

  // issue stage
  logic [CRD_W-1:0]  credit;
  logic              issue;
  logic              a_valid;
  band_t             a_band;
  band_t             a_seg;
  logic [SPAN_W-1:0] a_off;

  // multiply stage
  band_t                  a_nxt;
  logic [SPAN_W-1:0]      a_span;
  color_t                 c0_sel [3];
  logic                   neg_sel [3];
  logic [U_W-1:0]         u_sel [3];

  // division stages, index 0 is the multiply stage output
  logic                   valid [QUOT_W+1];
  band_t                  s_band [QUOT_W+1];
  logic [SPAN_W:0]        s_d2 [QUOT_W+1];
  logic [U_W-1:0]         rem [QUOT_W+1][3];
  logic [QUOT_W-1:0]      quo [QUOT_W+1][3];
  color_t                 s_c0 [QUOT_W+1][3];
  logic                   s_neg [QUOT_W+1][3];

  color_t                 color [3];

  // credits count words issued and not yet drained from the output queue
  assign issue   = !mid_empty && (credit < CRD_W'(OUT_DEPTH));
  assign mid_pop = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit  <= '0;
      a_valid <= 1'b0;
    end else begin
      credit  <= credit + CRD_W'(issue) - CRD_W'(drain);
      a_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      {a_band, a_seg, a_off} <= mid_word;
    end
  end

  // per channel: distance times color step, plus half rounding term
  assign a_nxt  = a_seg + 1'b1;
  assign a_span = SPAN_W'(span_m(a_seg)) << FRAC_BITS;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c0_sel[k]  = RGB[a_seg][k];
      neg_sel[k] = (RGB[a_nxt][k] < RGB[a_seg][k]);
      u_sel[k]   = {1'b0,
                    (SPAN_W+COLOR_W)'(a_off) * (SPAN_W+COLOR_W)'(neg_sel[k] ?
                      RGB[a_seg][k] - RGB[a_nxt][k] : RGB[a_nxt][k] - RGB[a_seg][k]),
                    1'b0}
                   + U_W'(a_span) - U_W'(neg_sel[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    s_band[0] <= a_band;
    s_d2[0]   <= {a_span, 1'b0};
    for (int k = 0; k < 3; k++) begin
      rem[0][k]   <= u_sel[k];
      quo[0][k]   <= '0;
      s_c0[0][k]  <= c0_sel[k];
      s_neg[0][k] <= neg_sel[k];
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < QUOT_W; s++) begin : g_div
    localparam int SH = QUOT_W - 1 - s;
    logic [U_W-1:0] trial;
    logic           take [3];

    assign trial = U_W'(s_d2[s]) << SH;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        take[k] = (rem[s][k] >= trial);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s+1] <= 1'b0;
      end else begin
        valid[s+1] <= valid[s];
      end
    end

    always_ff @(posedge clk) begin
      s_band[s+1] <= s_band[s];
      s_d2[s+1]   <= s_d2[s];
      for (int k = 0; k < 3; k++) begin
        rem[s+1][k]   <= take[k] ? rem[s][k] - trial : rem[s][k];
        quo[s+1][k]   <= {quo[s][k][QUOT_W-2:0], take[k]};
        s_c0[s+1][k]  <= s_c0[s][k];
        s_neg[s+1][k] <= s_neg[s][k];
      end
    end
  end

  // apply the signed step to the lower color
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      color[k] = s_neg[QUOT_W][k] ? s_c0[QUOT_W][k] - quo[QUOT_W][k]
                                  : s_c0[QUOT_W][k] + quo[QUOT_W][k];
    end
  end

  assign out_push = valid[QUOT_W];
  assign out_word = {s_band[QUOT_W], color[0], color[1], color[2]};

endmodule

// ===== src/elevation_color_ramp.sv =====
// elevation_color_ramp: hypsometric color ramp, top level
// depends on ecr_pkg, ecr_front, ecr_fifo, ecr_back
//
// Usage:
//   Input channel: drive elevation (signed, FRAC_BITS fraction bits) and
//   raise push; the word is taken at a clock edge with push high and full
//   low. Result channel: while empty is low, red, green, blue and band show
//   the oldest result; it is taken at an edge with pop high.
//   One result word comes out for each input word, in order.
// Pipeline: an accepted input word passes the middle queue write, the issue
//   register, the multiply stage, eight division stages and the output
//   queue write before empty falls for its result, when nothing waits ahead of it.
// Throughput: one word per cycle while the back holds a credit; the division
//   is pipelined one quotient bit per stage, so a new word enters every cycle.
// Stalls: the front writes classified words into a 4-word queue; the back
//   issues only while it holds a credit for the 16-word output queue, so
//   when pop stays low the output queue fills, then the middle queue, and
//   full rises. Nothing is dropped.
// Reset: rst (synchronous) empties both queues and the pipeline; full is
//   low and empty high after it. No tables are cleared.
module elevation_color_ramp
  import ecr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic signed [ELEV_W-1:0] elevation,
  output logic                     empty,
  input  logic                     pop,
  output logic [COLOR_W-1:0]       red,
  output logic [COLOR_W-1:0]       green,
  output logic [COLOR_W-1:0]       blue,
  output logic [BAND_W-1:0]        band
);

  localparam int SPAN_W = SPANM_W + FRAC_BITS;
  localparam int MID_W  = 2 * BAND_W + SPAN_W;
  localparam int OUT_W  = BAND_W + 3 * COLOR_W;

  band_t             f_band;
  band_t             f_seg;
  logic [SPAN_W-1:0] f_off;
  logic [MID_W-1:0]  mid_rdata;
  logic              mid_empty;
  logic              mid_pop;
  logic              out_push;
  logic [OUT_W-1:0]  out_wdata;
  logic [OUT_W-1:0]  out_rdata;
  logic              out_full;
  logic              drain;

  // front: classify the incoming word
  ecr_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .elevation(elevation),
    .band     (f_band),
    .seg      (f_seg),
    .off      (f_off)
  );

  // queue between front and back
  ecr_fifo #(
    .WIDTH(MID_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata({f_band, f_seg, f_off}),
    .full (full),
    .pop  (mid_pop),
    .rdata(mid_rdata),
    .empty(mid_empty)
  );

  // back: interpolation pipeline
  ecr_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .mid_empty(mid_empty),
    .mid_word (mid_rdata),
    .mid_pop  (mid_pop),
    .drain    (drain),
    .out_push (out_push),
    .out_word (out_wdata)
  );

  // output queue, never overflows thanks to the back's credits
  ecr_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .wdata(out_wdata),
    .full (out_full),
    .pop  (pop),
    .rdata(out_rdata),
    .empty(empty)
  );

  assign drain = pop && !empty;
  assign {band, red, green, blue} = out_rdata;

  // unused: the output queue is never full when the back pushes
  logic unused_full;
  assign unused_full = out_full;

endmodule

// ===== src/ecr_checker.sv =====
// ecr_checker: port-level checks for elevation_color_ramp, bound to the top
// depends on ecr_pkg and elevation_color_ramp
module ecr_checker
  import ecr_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     push,
  input logic                     full,
  input logic                     empty,
  input logic                     pop,
  input logic [COLOR_W-1:0]       red,
  input logic [COLOR_W-1:0]       green,
  input logic [COLOR_W-1:0]       blue,
  input logic [BAND_W-1:0]        band
);

  // the output queue comes out of reset empty and the input side not full
  a_reset_empty : assert property (@(posedge clk) $past(rst) |-> empty && !full)
    else $error("queues not empty after reset");

  // band index stays inside the ramp
  a_band_range : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (band <= BAND_W'(BREAKPOINTS - 1)))
    else $error("band out of range");

  // a waiting result holds while not popped
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(red) && $stable(green) && $stable(blue)
                       && $stable(band))
    else $error("waiting result changed");

  // the input side fills only through accepted words
  a_full_by_push : assert property (@(posedge clk) disable iff (rst)
    !full && !push |=> !full)
    else $error("full rose without an accepted word");

endmodule

bind elevation_color_ramp ecr_checker u_ecr_checker (.*);
